// File: rtl/pfra_pkg.sv
// pfra_pkg: shared types and constants of the page frame allocator
// action and status codes, register map, configuration bundle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfra_pkg;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_ALLOC   = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_SHARE   = 3'd3,
    ACT_QUERY   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NONE_FREE    = 3'd1,
    ST_NONEXISTENT  = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_IGNORED      = 3'd4,
    ST_SATURATED    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_FRAME_BASE = 2'd0,
    REG_FREE_START = 2'd1,
    REG_FREE_END   = 2'd2
  } reg_idx_e;

  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned COUNT_W        = 8;
  localparam int unsigned PADDR_W        = 4;

  localparam logic [COUNT_W-1:0] RESERVED_COUNT = 8'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

  localparam logic [ADDR_W-1:0] FRAME_BASE_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] FREE_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] FREE_END_RST   = 32'h8100_0000;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_base;
    logic [ADDR_W-1:0] free_start;
    logic [ADDR_W-1:0] free_end;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/pfra_ram.sv
// pfra_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/pfra_cfg.sv
// pfra_cfg: apb register file holding the frame base, free_start and free_end
// depends on pfra_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfra_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfra_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready,
  output      pfra_pkg::cfg_t                cfg_o
);

  pfra_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        pfra_pkg::REG_FRAME_BASE: cfg_d.frame_base = pwdata;
        pfra_pkg::REG_FREE_START: cfg_d.free_start = pwdata;
        pfra_pkg::REG_FREE_END:   cfg_d.free_end   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pfra_pkg::REG_FRAME_BASE: prdata = cfg_q.frame_base;
      pfra_pkg::REG_FREE_START: prdata = cfg_q.free_start;
      pfra_pkg::REG_FREE_END:   prdata = cfg_q.free_end;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base <= pfra_pkg::FRAME_BASE_RST;
      cfg_q.free_start <= pfra_pkg::FREE_START_RST;
      cfg_q.free_end   <= pfra_pkg::FREE_END_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/page_frame_refcount_allocator.sv
// page_frame_refcount_allocator: 8-bit reference counts per 4 KiB frame
// init computes the free range start, count and end, then sweeps all frames; alloc
// scans up to the first free frame; release/share/query locate, read, modify, ending
// at locate outside the frames; busy high meanwhile, not for an unknown action.
// reset: a clearing pass over all frames zeroes the counts, busy high.
// each result is a one-cycle done_o strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_refcount_allocator #(
  parameter int unsigned FRAMES = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [2:0]                    action_i,
  input  wire logic [31:0]                   page_addr_i,
  output      logic                          done_o,
  output      logic [31:0]                   frame_addr_o,
  output      logic [7:0]                    ref_count_o,
  output      logic [2:0]                    status_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfra_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);

  localparam int unsigned IW = $clog2(FRAMES);
  localparam int unsigned CW = IW + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_S,
    S_INIT_N,
    S_INIT_E,
    S_INIT_SWEEP,
    S_SCAN,
    S_LOC,
    S_RD,
    S_MOD
  } state_e;

  pfra_pkg::cfg_t cfg;

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  pfra_pkg::action_e  act_q, act_d;
  logic [31:0]        addr_q, addr_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic signed [20:0] s_q, s_d;
  logic [19:0]        n_q, n_d;
  logic signed [21:0] e_q, e_d;
  logic               chk_vld_q, chk_vld_d;
  logic [IW-1:0]      chk_idx_q, chk_idx_d;
  logic               done_q, done_d;
  logic [31:0]        faddr_q, faddr_d;
  logic [7:0]         count_q, count_d;
  logic [2:0]         status_q, status_d;

  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata, mem_rdata;

  logic [32:0]        diff_w;
  logic [32:0]        fs_diff_w;
  logic signed [21:0] sweep_idx_w;
  logic               in_range_w;

  pfra_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfra_ram #(
    .WIDTH (pfra_pkg::COUNT_W),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign frame_addr_o = faddr_q;
  assign ref_count_o  = count_q;
  assign status_o     = status_q;

  // frame offset of the item address, bit 32 set when below base
  assign diff_w    = {1'b0, addr_q} - {1'b0, cfg.frame_base};
  // floor of (free_start - frame_base) / 4096 is the signed top of this difference
  assign fs_diff_w = {1'b0, cfg.free_start} - {1'b0, cfg.frame_base};

  assign sweep_idx_w = $signed({{(22-IW){1'b0}}, cnt_q[IW-1:0]});
  assign in_range_w  = (sweep_idx_w >= $signed({s_q[20], s_q})) && (sweep_idx_w < e_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    act_d     = act_q;
    addr_d    = addr_q;
    idx_d     = idx_q;
    s_d       = s_q;
    n_d       = n_q;
    e_d       = e_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    done_d    = 1'b0;
    faddr_d   = faddr_q;
    count_d   = count_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[IW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cnt_q[IW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          act_d    = pfra_pkg::action_e'(action_i);
          addr_d   = page_addr_i;
          cnt_d    = '0;
          faddr_d  = '0;
          count_d  = '0;
          status_d = pfra_pkg::ST_OK;
          case (action_i) inside
            pfra_pkg::ACT_INIT:  state_d = S_INIT_S;
            pfra_pkg::ACT_ALLOC: state_d = S_SCAN;
            pfra_pkg::ACT_RELEASE, pfra_pkg::ACT_SHARE, pfra_pkg::ACT_QUERY:
              state_d = S_LOC;
            default: begin
              status_d = pfra_pkg::ST_IGNORED;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      S_INIT_S: begin
        s_d     = $signed(fs_diff_w[32:12]);
        state_d = S_INIT_N;
      end

      S_INIT_N: begin
        if (cfg.free_end > cfg.free_start) begin
          n_d = 20'((cfg.free_end - cfg.free_start) >> pfra_pkg::PAGE_SHIFT);
        end else begin
          n_d = '0;
        end
        state_d = S_INIT_E;
      end

      S_INIT_E: begin
        e_d     = $signed({s_q[20], s_q}) + $signed({2'b00, n_q});
        state_d = S_INIT_SWEEP;
      end

      S_INIT_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = in_range_w ? '0 : pfra_pkg::RESERVED_COUNT;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(FRAMES - 1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        // reads run one frame ahead of the zero check
        if (cnt_q < CW'(FRAMES)) begin
          mem_re    = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_q[IW-1:0];
        end
        if (chk_vld_q && mem_rdata == '0) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_q;
          mem_wdata = 8'd1;
          chk_vld_d = 1'b0;
          faddr_d   = cfg.frame_base + 32'({chk_idx_q, 12'h000});
          count_d   = 8'd1;
          status_d  = pfra_pkg::ST_OK;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else if (chk_vld_q && chk_idx_q == IW'(FRAMES - 1)) begin
          chk_vld_d = 1'b0;
          status_d  = pfra_pkg::ST_NONE_FREE;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_LOC: begin
        idx_d = diff_w[12 +: IW];
        if (diff_w[32]) begin
          status_d = pfra_pkg::ST_IGNORED;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (diff_w[31:12] >= 20'(FRAMES)) begin
          status_d = pfra_pkg::ST_NONEXISTENT;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_RD;
        end
      end

      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
        state_d   = S_MOD;
      end

      S_MOD: begin
        mem_waddr = idx_q;
        done_d    = 1'b1;
        state_d   = S_IDLE;
        case (act_q)
          pfra_pkg::ACT_RELEASE: begin
            if (mem_rdata == '0) begin
              status_d = pfra_pkg::ST_ALREADY_FREE;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata - 1'b1;
              count_d   = mem_rdata - 1'b1;
            end
          end
          pfra_pkg::ACT_SHARE: begin
            if (mem_rdata == pfra_pkg::COUNT_MAX) begin
              status_d = pfra_pkg::ST_SATURATED;
              count_d  = mem_rdata;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata + 1'b1;
              count_d   = mem_rdata + 1'b1;
            end
          end
          default: count_d = mem_rdata;
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      act_q     <= pfra_pkg::ACT_INIT;
      addr_q    <= '0;
      idx_q     <= '0;
      s_q       <= '0;
      n_q       <= '0;
      e_q       <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      done_q    <= 1'b0;
      faddr_q   <= '0;
      count_q   <= '0;
      status_q  <= pfra_pkg::ST_OK;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      act_q     <= act_d;
      addr_q    <= addr_d;
      idx_q     <= idx_d;
      s_q       <= s_d;
      n_q       <= n_d;
      e_q       <= e_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      done_q    <= done_d;
      faddr_q   <= faddr_d;
      count_q   <= count_d;
      status_q  <= status_d;
    end
  end

endmodule

`default_nettype wire
